>>> sv/cpfm_pkg.sv
// Package for the capture period frequency meter.
// Word types, field widths and divider constants shared by every module.
// No dependencies.
package cpfm_pkg;

  // Field widths fixed by the interface
  localparam int CAP_W   = 16;
  localparam int FREQ_W  = 27;
  localparam int STAMP_W = 32;

  // Defaults for the top-level parameters
  localparam int TIMER_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Tick rate after reset
  localparam logic [FREQ_W-1:0] TICK_RATE_RESET = FREQ_W'(500000);

  // Radix-2 divider: one quotient bit per step
  localparam int DIV_STEPS = FREQ_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  // Event kinds
  localparam logic CMD_OVERFLOW = 1'b0;
  localparam logic CMD_CAPTURE  = 1'b1;

  // Input word
  typedef struct packed {
    logic             cmd;
    logic [CAP_W-1:0] capture_value;
    logic             wrap_pending;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [FREQ_W-1:0] frequency;
    logic              updated;
  } out_word_t;

  // Job handed from the front end to the divider side
  typedef struct packed {
    logic               div;
    logic [STAMP_W-1:0] period;
  } job_t;

endpackage

>>> sv/cpfm_front.sv
// Front end: wrap counting, timestamp extension and period calculation.
// Turns each accepted word into one job for the back end. Uses cpfm_pkg.
module cpfm_front import cpfm_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_push_i,
  input  in_word_t in_i,
  output logic     job_push_o,
  output job_t     job_o
);

  localparam int WRAP_W = (TIMER_BITS >= STAMP_W) ? 1 : STAMP_W - TIMER_BITS;
  localparam bit HAS_WRAP = (TIMER_BITS < STAMP_W);
  localparam logic [CAP_W-1:0] CNT_MASK = (TIMER_BITS >= CAP_W) ? {CAP_W{1'b1}} :
      CAP_W'((33'd1 << TIMER_BITS) - 33'd1);
  localparam logic [STAMP_W:0] HALF = (STAMP_W + 1)'(33'd1 << (TIMER_BITS - 1));

  logic [WRAP_W-1:0]  wrap_q, wrap_d;
  logic [STAMP_W-1:0] last_q, last_d;
  logic               primed_q, primed_d;

  logic [CAP_W-1:0]   count;
  logic               low_half;
  logic [STAMP_W-1:0] wraps;
  logic [STAMP_W-1:0] stamp;
  logic [STAMP_W-1:0] period;

  // Extend the captured count to a full timestamp
  always_comb begin
    count    = in_i.capture_value & CNT_MASK;
    low_half = ({{(STAMP_W + 1 - CAP_W){1'b0}}, count} < HALF);
    wraps    = STAMP_W'(wrap_q) + STAMP_W'(in_i.wrap_pending && low_half);
    stamp    = HAS_WRAP ? ((wraps << TIMER_BITS) | STAMP_W'(count)) : STAMP_W'(count);
    period   = stamp - last_q;
  end

  // State update and job build
  always_comb begin
    wrap_d     = wrap_q;
    last_d     = last_q;
    primed_d   = primed_q;
    job_push_o = in_push_i;
    job_o.div    = 1'b0;
    job_o.period = period;
    if (in_push_i) begin
      if (in_i.cmd == CMD_OVERFLOW) begin
        wrap_d = HAS_WRAP ? wrap_q + WRAP_W'(1) : '0;
      end else begin
        job_o.div = primed_q && (period != '0);
        primed_d  = 1'b1;
        last_d    = stamp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q   <= '0;
      last_q   <= '0;
      primed_q <= 1'b0;
    end else begin
      wrap_q   <= wrap_d;
      last_q   <= last_d;
      primed_q <= primed_d;
    end
  end

`ifndef ASSERT_OFF
  // A division job only ever follows a first capture
  a_div_needs_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_push_o && job_o.div) |-> primed_q)
    else $error("division job issued before priming");
`endif

endmodule

>>> sv/cpfm_queue.sv
// Short job queue between front end and back end, held in flip-flops.
// Depth set by parameter. Uses cpfm_pkg for the job type.
module cpfm_queue import cpfm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wptr_q, wptr_d;
  logic [AW-1:0] rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) wptr_d = (wptr_q == LAST) ? '0 : wptr_q + AW'(1);
    if (do_pop)  rptr_d = (rptr_q == LAST) ? '0 : rptr_q + AW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CW'(1);
    if (do_pop && !do_push) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("job queue overfilled");
`endif

endmodule

>>> sv/cpfm_back.sv
// Back end: radix-2 divider, frequency hold and the result register.
// Takes jobs from the queue and emits one result word per job. Uses cpfm_pkg.
module cpfm_back import cpfm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [FREQ_W-1:0] tick_rate_i,
  input  logic              job_empty_i,
  input  job_t              job_i,
  output logic              job_pop_o,
  output logic              out_empty_o,
  input  logic              out_pop_i,
  output out_word_t         out_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic               state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [STAMP_W-1:0] rem_q, rem_d;
  logic [STAMP_W-1:0] dsr_q, dsr_d;
  logic [FREQ_W-1:0]  quo_q, quo_d;
  logic [FREQ_W-1:0]  hold_q, hold_d;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_q, out_d;
  logic               out_load;
  logic               out_free;
  logic [STAMP_W:0]   rem_sh;
  logic [STAMP_W:0]   rem_sub;
  logic               ge;

  assign out_empty_o = !out_valid_q;
  assign out_o       = out_q;
  assign out_free    = !out_valid_q || out_pop_i;

  // One restoring divide step
  always_comb begin
    rem_sh  = {rem_q, quo_q[FREQ_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    ge      = (rem_sh >= {1'b0, dsr_q});
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    rem_d     = rem_q;
    dsr_d     = dsr_q;
    quo_d     = quo_q;
    hold_d    = hold_q;
    out_d     = out_q;
    out_load  = 1'b0;
    job_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!job_empty_i) begin
          if (job_i.div) begin
            job_pop_o = 1'b1;
            state_d   = ST_DIV;
            step_d    = '0;
            rem_d     = '0;
            dsr_d     = job_i.period;
            quo_d     = tick_rate_i;
          end else if (out_free) begin
            job_pop_o = 1'b1;
            out_load  = 1'b1;
            out_d.frequency = hold_q;
            out_d.updated   = 1'b0;
          end
        end
      end
      ST_DIV: begin
        if (step_q != STEP_W'(DIV_STEPS)) begin
          step_d = step_q + STEP_W'(1);
          rem_d  = ge ? rem_sub[STAMP_W-1:0] : rem_sh[STAMP_W-1:0];
          quo_d  = {quo_q[FREQ_W-2:0], ge};
        end else if (out_free) begin
          out_load = 1'b1;
          hold_d   = quo_q;
          out_d.frequency = quo_q;
          out_d.updated   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_pop_i && out_valid_q) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      hold_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      hold_q      <= hold_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
    out_q <= out_d;
  end

`ifndef ASSERT_OFF
  a_dsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (dsr_q != '0))
    else $error("divider running with zero period");
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (step_q <= STEP_W'(DIV_STEPS)))
    else $error("divider step count out of range");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> (state_q == ST_IDLE))
    else $error("job taken while divider busy");
`endif

endmodule

>>> sv/capture_period_frequency_meter.sv
// Ticks, first captures and zero periods pass the job queue, then the result register;
// other captures pass the queue, the 27-step radix-2 divider, then the result register.
// Throughput: one word per cycle without a division, while the divider is idle and the
// result register free; one division at a time; a 2-deep job queue takes ticks meanwhile.
// Reset (rst_ni, async, active low) clears wrap count, timestamp, priming, frequency
// to zero and loads the tick rate with 500000.
module capture_period_frequency_meter import cpfm_pkg::*; #(
  parameter int TIMER_BITS  = TIMER_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  in_word_t          in_i,
  output logic              empty,
  input  logic              pop,
  output out_word_t         out_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [FREQ_W-1:0] cfg_data_i
);

  logic [FREQ_W-1:0] tick_rate_q, tick_rate_d;
  logic              in_push;
  logic              job_push;
  job_t              job_in;
  logic              job_full;
  logic              job_pop;
  logic              job_empty;
  job_t              job_out;

  // Tick rate register, always ready
  assign cfg_ready_o = 1'b1;
  assign tick_rate_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : tick_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tick_rate_q <= TICK_RATE_RESET;
    else         tick_rate_q <= tick_rate_d;
  end

  // Input word accepted when the job queue has room
  assign full    = job_full;
  assign in_push = push && !job_full;

  cpfm_front #(
    .TIMER_BITS (TIMER_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_push_i  (in_push),
    .in_i       (in_i),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  cpfm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .data_o  (job_out)
  );

  cpfm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_rate_i (tick_rate_q),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .out_empty_o (empty),
    .out_pop_i   (pop),
    .out_o       (out_o)
  );

`ifndef ASSERT_OFF
  // A flagged update never reports more than the tick rate
  a_freq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.updated && $stable(tick_rate_q)) |-> (out_o.frequency <= tick_rate_q))
    else $error("frequency above tick rate");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Testbench for capture_period_frequency_meter: drives timer events, predicts each result word.
// Depends on cpfm_pkg and the meter RTL; self-checking, prints one final verdict line.
module testbench;
  import cpfm_pkg::*;

  localparam int          HOLDOFF_CYCLES = 150;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          SETTLE_CYCLES  = 40;
  localparam logic [15:0] HALF_RANGE     = 16'h8000;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              push      = 1'b0;
  logic              full;
  in_word_t          in_word   = '0;
  logic              empty;
  logic              pop       = 1'b0;
  out_word_t         out_word;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [FREQ_W-1:0] cfg_data  = '0;

  // Predictor state, mirrors the meter after reset
  logic [FREQ_W-1:0]  meter_tick_rate  = TICK_RATE_RESET;
  logic [CAP_W-1:0]   meter_wraps      = '0;
  logic [STAMP_W-1:0] meter_last_stamp = '0;
  logic               meter_primed     = 1'b0;
  logic [FREQ_W-1:0]  meter_freq       = '0;
  out_word_t          freq_expect_q[$];

  // Sender pacing and receiver hold-off
  int unsigned  burst_left    = 0;
  bit           steady_sender = 1'b0;
  int unsigned  items_sent    = 0;
  int unsigned  mismatches    = 0;
  logic         holdoff_req   = 1'b0;   // toggled by the test to request a hold-off
  logic         holdoff_ack   = 1'b0;   // follows the request once the hold-off ends
  int unsigned  holdoff_left  = 0;
  logic [15:0]  pop_pattern   = 16'hFFFF;
  logic [5:0]   pace_cycle    = '0;
  logic [31:0]  timer_now     = '0;

  capture_period_frequency_meter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_word),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #6 clk_i = ~clk_i;

  // Expected result word for one event; advances the predictor state
  function automatic out_word_t meter_step(input in_word_t w);
    out_word_t          res;
    logic [CAP_W-1:0]   wraps;
    logic [STAMP_W-1:0] stamp;
    logic [STAMP_W-1:0] period;
    res.updated = 1'b0;
    if (w.cmd == CMD_OVERFLOW) begin
      meter_wraps = meter_wraps + 1'b1;
    end else begin
      wraps = meter_wraps;
      // pending overflow belongs to this capture only if the count already restarted
      if (w.wrap_pending && w.capture_value < HALF_RANGE) wraps = wraps + 1'b1;
      stamp = {wraps, w.capture_value};
      if (meter_primed) begin
        period = stamp - meter_last_stamp;
        if (period != '0) begin
          meter_freq  = FREQ_W'(meter_tick_rate / period);
          res.updated = 1'b1;
        end
      end else begin
        meter_primed = 1'b1;
      end
      meter_last_stamp = stamp;
    end
    res.frequency = meter_freq;
    return res;
  endfunction

  // Offer one word, wait until it is taken, record its expected result
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    if (!steady_sender) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 8);
        if (gap != 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      end
      burst_left--;
    end
    push    <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (full);
    freq_expect_q.push_back(meter_step(w));
    items_sent++;
  endtask

  task automatic send_tick();
    in_word_t w;
    w.cmd           = CMD_OVERFLOW;
    w.capture_value = CAP_W'($urandom);
    w.wrap_pending  = 1'($urandom);
    send_word(w);
  endtask

  task automatic send_capture(input logic [CAP_W-1:0] value, input logic pending);
    in_word_t w;
    w.cmd           = CMD_CAPTURE;
    w.capture_value = value;
    w.wrap_pending  = pending;
    send_word(w);
  endtask

  // Stop offering and wait until every expected word has come back
  task automatic drain_results();
    push      <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (freq_expect_q.size() != 0);
  endtask

  task automatic set_tick_rate(input logic [FREQ_W-1:0] rate);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= rate;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid      <= 1'b0;
    meter_tick_rate = rate;
  endtask

  // One signal edge of a synthetic input: overflow ticks for each timer wrap, then the capture
  task automatic send_signal_edge();
    int unsigned      step;
    int unsigned      crossed;
    logic [31:0]      t_next;
    logic [CAP_W-1:0] count;
    bit               late;
    case ($urandom_range(0, 4))
      0:       step = $urandom_range(0, 3);
      1:       step = $urandom_range(4, 300);
      2:       step = $urandom_range(300, 20000);
      3:       step = $urandom_range(20000, 140000);
      default: step = $urandom_range(140000, 1 << 20);
    endcase
    t_next  = timer_now + step;
    crossed = 16'(t_next[31:16] - timer_now[31:16]);
    count   = t_next[15:0];
    late    = crossed != 0 && count < HALF_RANGE && $urandom_range(0, 2) == 0;
    repeat (crossed - late) send_tick();
    // a flag with a high count stands for an overflow that came after the capture
    send_capture(count, late || (count >= 16'hC000 && $urandom_range(0, 3) == 0));
    if (late) send_tick();
    timer_now = t_next;
  endtask

  // Check every result word taken from the meter
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && pop && !empty) begin
      if (freq_expect_q.size() == 0) begin
        $display("%0t: unexpected word, expected none actual freq %0d upd %0d",
                 $time, out_word.frequency, out_word.updated);
        mismatches++;
      end else begin
        want = freq_expect_q.pop_front();
        if (out_word.frequency !== want.frequency) begin
          $display("%0t: frequency mismatch, expected %0d actual %0d",
                   $time, want.frequency, out_word.frequency);
          mismatches++;
        end
        if (out_word.updated !== want.updated) begin
          $display("%0t: updated mismatch, expected %0d actual %0d",
                   $time, want.updated, out_word.updated);
          mismatches++;
        end
      end
    end
  end

  // Receiver: rotating stall pattern, or a long hold-off on request
  always @(posedge clk_i) begin
    pace_cycle <= pace_cycle + 1'b1;
    if (holdoff_req != holdoff_ack) begin
      pop <= 1'b0;
      if (holdoff_left == HOLDOFF_CYCLES - 1) begin
        holdoff_ack  <= holdoff_req;
        holdoff_left <= 0;
      end else begin
        holdoff_left <= holdoff_left + 1;
      end
    end else begin
      pop <= pop_pattern[0];
      if (pace_cycle == '0) begin
        case ($urandom_range(0, 3))
          0:       pop_pattern <= 16'hFFFF;
          1:       pop_pattern <= 16'($urandom) | 16'h0001;
          2:       pop_pattern <= 16'h0001 << $urandom_range(0, 15);
          default: pop_pattern <= 16'h5555;
        endcase
      end else begin
        pop_pattern <= {pop_pattern[0], pop_pattern[15:1]};
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no word moving
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    do begin
      @(posedge clk_i);
      if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end while (quiet < WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Ticks, priming, zero periods and the pending-wrap boundary at reset tick rate
  task automatic test_directed_events();
    send_word(in_word_t'({CMD_OVERFLOW, {CAP_W{1'b1}}, 1'b1}));
    send_word(in_word_t'({CMD_OVERFLOW, {CAP_W{1'b0}}, 1'b0}));
    send_capture(16'h0000, 1'b0);   // first capture only primes
    send_capture(16'h0000, 1'b0);   // zero period keeps frequency
    send_capture(16'h0001, 1'b0);
    send_capture(16'hFFFF, 1'b1);   // flag ignored in upper half
    send_capture(16'h7FFF, 1'b1);   // extra wrap in lower half
    send_capture(16'h8000, 1'b1);   // goes backward, huge modular period
    send_tick();
    send_capture(16'h0000, 1'b1);
    send_tick();                    // the pending tick arrives late
    send_capture(16'h0000, 1'b0);   // same stamp again
    send_capture(16'hAAAA, 1'b0);
    send_capture(16'h5555, 1'b1);
    send_capture(16'h5556, 1'b0);
    send_tick();
    send_capture(16'h5556, 1'b0);   // exactly one wrap
    drain_results();
  endtask

  // Extremes of the tick rate register, including zero
  task automatic test_tick_rate_extremes();
    logic [FREQ_W-1:0] rates[5];
    logic [CAP_W-1:0]  base;
    rates = '{FREQ_W'(1), FREQ_W'(0), FREQ_W'(100000000), {FREQ_W{1'b1}}, TICK_RATE_RESET};
    foreach (rates[i]) begin
      set_tick_rate(rates[i]);
      base = CAP_W'($urandom_range(0, 16'hFFF0));
      send_capture(base, 1'b0);
      send_capture(base + 1'b1, 1'b0);
      send_capture(base + 3'd4, 1'b0);
      send_tick();
      send_capture(base + 3'd4, 1'b0);
    end
  endtask

  // Receiver holds off while the sender keeps offering: input side must stall
  task automatic test_backpressure();
    drain_results();
    holdoff_req  <= !holdoff_req;
    steady_sender = 1'b1;
    repeat (24) begin
      if ($urandom_range(0, 2) == 0) send_tick();
      else send_capture(CAP_W'($urandom), 1'($urandom));
    end
    steady_sender = 1'b0;
    drain_results();
  endtask

  // Synthetic signal traffic with some noise, over several tick rates
  task automatic test_random_traffic();
    int unsigned start;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       set_tick_rate(TICK_RATE_RESET);
        1:       set_tick_rate(FREQ_W'($urandom_range(1, 2000)));
        default: set_tick_rate(FREQ_W'($urandom_range(1, 100000000)));
      endcase
      steady_sender = phase == 3;
      start = items_sent;
      while (items_sent - start < 75) begin
        if ($urandom_range(0, 6) == 0) send_word(in_word_t'(18'($urandom)));
        else send_signal_edge();
      end
    end
    steady_sender = 1'b0;
    drain_results();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_events();
    test_tick_rate_extremes();
    test_backpressure();
    test_random_traffic();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && freq_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/cpfm_pkg.sv
sv/cpfm_front.sv
sv/cpfm_queue.sv
sv/cpfm_back.sv
sv/capture_period_frequency_meter.sv
tb/sv/testbench.sv
